>>> design/segmented_prime_sieve_assert.svh
// Assertion macros for the sieve modules; the datapath uses them.
// Each macro expects clk_i, and SPS_ASSERT also rst_ni, to be visible where it is used.
`ifndef SEGMENTED_PRIME_SIEVE_ASSERT_SVH
`define SEGMENTED_PRIME_SIEVE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sieve assertion failed");
`define SPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sieve assertion failed");
`else
`define SPS_ASSERT(lbl, prop)
`define SPS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> design/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;

  localparam int SEGMENT_DEPTH = 16384;
  localparam int NUM_W         = 32;
  localparam int LEN_W         = 15;
  localparam int WALK_W        = 33;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_STRIKE  = 2'd1;
  localparam logic [1:0] KIND_EXAMINE = 2'd2;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [NUM_W-1:0] known_prime;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [NUM_W-1:0] prime_value;
    logic             last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DIV,
    ST_WALK,
    ST_EXAM
  } state_e;

  typedef struct packed {
    logic take;
    logic fill_step;
    logic walk_load_div;
    logic walk_step;
    logic exam_load;
  } cmd_t;

  typedef struct packed {
    logic p_ge2;
    logic fill_last;
    logic div_done;
    logic walk_done;
    logic out_free;
    logic exam_found;
  } status_t;

endpackage

>>> design/sps_div.sv
`timescale 1ns / 1ps
// Restoring divider, one remainder bit per cycle; only the remainder is kept.
module sps_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sps_pkg::NUM_W-1:0]   dividend_i,
  input  logic [sps_pkg::NUM_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [sps_pkg::NUM_W-1:0]   rem_o
);

  localparam int W  = sps_pkg::NUM_W;
  localparam int CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  num_q;
  logic [W-1:0]  den_q;
  logic [W-1:0]  rem_q;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem_q, num_q[W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], 1'b0};
      rem_q <= ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> design/sps_dp.sv
`timescale 1ns / 1ps
`include "segmented_prime_sieve_assert.svh"
// Sieve datapath: configuration, candidate bitmap, cursor, strike walker and result register.
module sps_dp #(
  parameter int SegmentDepth = sps_pkg::SEGMENT_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sps_pkg::in_t                in_data_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output sps_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [sps_pkg::NUM_W-1:0]   cfg_data_i,
  input  sps_pkg::cmd_t               cmd_i,
  output sps_pkg::status_t            st_o
);

  localparam int AW = $clog2(SegmentDepth);
  localparam int NW = sps_pkg::NUM_W;
  localparam int LW = sps_pkg::LEN_W;
  localparam int WW = sps_pkg::WALK_W;

  logic [NW-1:0] base_q;
  logic [LW-1:0] length_q;
  logic [LW-1:0] cursor_q;
  logic [NW-1:0] prime_q;
  logic [AW-1:0] fill_idx_q;
  logic [WW-1:0] walk_idx_q;
  logic [NW-1:0] step_q;
  logic          rdata_q;
  logic          out_valid_q;
  sps_pkg::out_t out_q;
  logic          mem_q [SegmentDepth];

  logic [WW-1:0] len33;
  logic [WW-1:0] cur33;
  logic [WW-1:0] value33;
  logic          at_end;
  logic          over;
  logic          found;
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] rem;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;

  // Effective length is the configured length saturated to the bitmap depth.
  assign len33 = ({{(WW-LW){1'b0}}, length_q} > WW'(SegmentDepth)) ?
                 WW'(SegmentDepth) : {{(WW-LW){1'b0}}, length_q};
  assign cur33   = {{(WW-LW){1'b0}}, cursor_q};
  assign value33 = {1'b0, base_q} + cur33;
  assign at_end  = cur33 >= len33;
  assign over    = value33[WW-1];
  assign found   = !at_end && !over && (value33 >= WW'(2)) && rdata_q;

  assign div_start = cmd_i.take && (in_data_i.kind == sps_pkg::KIND_STRIKE) &&
                     (in_data_i.known_prime >= NW'(2));

  sps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (base_q),
    .divisor_i  (in_data_i.known_prime),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= NW'(2);
      length_q    <= '0;
      cursor_q    <= '0;
      fill_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sps_pkg::CFG_BASE:   base_q   <= cfg_data_i;
          sps_pkg::CFG_LENGTH: length_q <= cfg_data_i[LW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.take && in_data_i.kind == sps_pkg::KIND_START) begin
        cursor_q   <= '0;
        fill_idx_q <= '0;
      end else if (cmd_i.fill_step) begin
        fill_idx_q <= fill_idx_q + 1'b1;
      end
      if (cmd_i.exam_load && !at_end) begin
        cursor_q <= cursor_q + 1'b1;
      end
      if (cmd_i.exam_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      prime_q <= in_data_i.known_prime;
    end
    if (cmd_i.walk_load_div) begin
      walk_idx_q <= (rem == '0) ? '0 : WW'(prime_q - rem);
      step_q     <= prime_q;
    end else if (cmd_i.exam_load) begin
      walk_idx_q <= cur33 + value33;
      step_q     <= value33[NW-1:0];
    end else if (cmd_i.walk_step) begin
      walk_idx_q <= walk_idx_q + {1'b0, step_q};
    end
    if (cmd_i.exam_load) begin
      out_q.found       <= found;
      out_q.prime_value <= (at_end || over) ? '0 : value33[NW-1:0];
      out_q.last        <= at_end;
    end
  end

  // Bitmap: one write port (fill or strike), one registered read port (examine).
  assign mem_we    = cmd_i.fill_step || cmd_i.walk_step;
  assign mem_waddr = cmd_i.fill_step ? fill_idx_q : walk_idx_q[AW-1:0];
  assign mem_re    = cmd_i.take && (in_data_i.kind == sps_pkg::KIND_EXAMINE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= cmd_i.fill_step;
    end
    if (mem_re) begin
      rdata_q <= mem_q[cur33[AW-1:0]];
    end
  end

  assign st_o.p_ge2      = in_data_i.known_prime >= NW'(2);
  assign st_o.fill_last  = fill_idx_q == AW'(SegmentDepth - 1);
  assign st_o.div_done   = div_done;
  assign st_o.walk_done  = walk_idx_q >= len33;
  assign st_o.out_free   = !out_valid_q || !out_stall_i;
  assign st_o.exam_found = found;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SPS_ASSERT(a_exam_needs_room, cmd_i.exam_load |-> (!out_valid_q || !out_stall_i))
  `SPS_ASSERT(a_strike_in_segment, cmd_i.walk_step |-> (walk_idx_q < len33))
  `SPS_ASSERT(a_start_clears_cursor,
    (cmd_i.take && in_data_i.kind == sps_pkg::KIND_START) |=> (cursor_q == '0))

endmodule

>>> design/sps_ctrl.sv
`timescale 1ns / 1ps
// Sieve sequencer: takes one item and steps the datapath through its work.
module sps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_kind_i,
  output logic              in_stall_o,
  output sps_pkg::cmd_t     cmd_o,
  input  sps_pkg::status_t  st_i
);

  sps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      sps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (in_kind_i)
            sps_pkg::KIND_START:   state_d = sps_pkg::ST_FILL;
            sps_pkg::KIND_STRIKE:  state_d = st_i.p_ge2 ? sps_pkg::ST_DIV : sps_pkg::ST_IDLE;
            sps_pkg::KIND_EXAMINE: state_d = sps_pkg::ST_EXAM;
            default:               state_d = sps_pkg::ST_IDLE;
          endcase
        end
      end
      sps_pkg::ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (st_i.fill_last) begin
          state_d = sps_pkg::ST_IDLE;
        end
      end
      sps_pkg::ST_DIV: begin
        if (st_i.div_done) begin
          cmd_o.walk_load_div = 1'b1;
          state_d = sps_pkg::ST_WALK;
        end
      end
      sps_pkg::ST_WALK: begin
        if (st_i.walk_done) begin
          state_d = sps_pkg::ST_IDLE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      sps_pkg::ST_EXAM: begin
        if (st_i.out_free) begin
          cmd_o.exam_load = 1'b1;
          state_d = st_i.exam_found ? sps_pkg::ST_WALK : sps_pkg::ST_IDLE;
        end
      end
      default: state_d = sps_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> design/segmented_prime_sieve.sv
// A start takes the item and then sweeps the whole bitmap to candidate. A strike with a known
// prime of 2 or more runs the serial remainder, then strikes each multiple and ends the walk.
// An examine reads the bit at the cursor and waits while a stalled result holds the output
// register; a found prime then has its multiples struck before the walk ends.
// Only one item is in work at a time; the single bitmap write port paces the fill and the strike walk.
// Reset: control state clears, base reads 2, length 0; the bitmap is undefined until a start.
`timescale 1ns / 1ps
module segmented_prime_sieve #(
  parameter int SegmentDepth = sps_pkg::SEGMENT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sps_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sps_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [sps_pkg::NUM_W-1:0]  cfg_data_i
);

  // The sequencer accepts a beat only when idle. A start beat sweeps the whole
  // bitmap to candidate, a strike beat runs the serial remainder and then walks
  // the multiples, and an examine beat reads the bit at the cursor and posts the
  // result into the output register; a found prime's multiples are walked before idle.
  sps_pkg::cmd_t    cmd;
  sps_pkg::status_t st;

  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  sps_dp #(
    .SegmentDepth (SegmentDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule
